[rtl/core/scrolled_nibble_pixel_layer_macros.svh]
// assertion helpers used by the layer back end (snpl_back)
`ifndef SCROLLED_NIBBLE_PIXEL_LAYER_MACROS_SVH
`define SCROLLED_NIBBLE_PIXEL_LAYER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SNPL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("snpl check failed");

// next-cycle implication, disabled while in reset
`define SNPL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("snpl check failed");

`endif

[rtl/core/snpl_pkg.sv]
`timescale 1ns / 1ps
package snpl_pkg;

	localparam int ADDR_W    = 18;
	localparam int DATA_W    = 16;
	localparam int MASK_W    = 2;
	localparam int SX_W      = 9;
	localparam int SY_W      = 8;
	localparam int SCROLL_W  = 11;
	localparam int NIB_W     = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_RIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_LEFT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPLIT        = 2'd2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// lane enables inside byte_mask
	localparam int MASK_EVEN_BIT = 1;
	localparam int MASK_ODD_BIT  = 0;

	typedef struct packed {
		logic             is_rd;
		logic             odd_sel;
		logic             even_we;
		logic             odd_we;
		logic [NIB_W-1:0] even_nib;
		logic [NIB_W-1:0] odd_nib;
	} snpl_cmd_t;

endpackage

[rtl/core/snpl_ifs.sv]
`timescale 1ns / 1ps
interface snpl_req_if import snpl_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                op;
	logic [ADDR_W-1:0]   word_addr;
	logic [DATA_W-1:0]   write_data;
	logic [MASK_W-1:0]   byte_mask;
	logic [SX_W-1:0]     screen_x;
	logic [SY_W-1:0]     screen_y;

	modport source (output valid, op, word_addr, write_data, byte_mask, screen_x, screen_y,
		input ready);
	modport sink (input valid, op, word_addr, write_data, byte_mask, screen_x, screen_y,
		output ready);
endinterface

interface snpl_rsp_if import snpl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [NIB_W-1:0] pixel_nibble;
	logic             opaque;

	modport source (output valid, pixel_nibble, opaque, input ready);
	modport sink (input valid, pixel_nibble, opaque, output ready);
endinterface

interface snpl_cfg_if import snpl_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [SCROLL_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/snpl_front.sv]
`timescale 1ns / 1ps
module snpl_front import snpl_pkg::*; #(
	parameter int LAYER_WIDTH  = 2048,
	parameter int LAYER_HEIGHT = 256,
	parameter int SPLIT_COLUMN = 160,
	parameter int IW           = 18
) (
	input  logic             clk,
	input  logic             arst_n,
	snpl_req_if.sink         req,
	snpl_cfg_if.sink         cfg,
	input  logic             clr_busy,
	input  logic             q_full,
	output logic             push,
	output snpl_cmd_t        push_cmd,
	output logic [IW-1:0]    push_idx
);

	localparam int XW    = $clog2(LAYER_WIDTH);
	localparam int YW    = $clog2(LAYER_HEIGHT);
	localparam int AW    = (IW > ADDR_W) ? IW : ADDR_W;
	localparam int SUM_W = SCROLL_W + 1;
	localparam int YE_W  = YW + SY_W;

	logic [SCROLL_W-1:0] scroll_right_q;
	logic [SCROLL_W-1:0] scroll_left_q;
	logic                split_q;

	logic [SCROLL_W-1:0] scroll;
	logic [SUM_W-1:0]    lx_sum;
	logic [XW-1:0]       lx;
	logic [YE_W-1:0]     sy_ext;
	logic [YW-1:0]       ly;
	logic [IW-1:0]       rd_idx;
	logic [AW-1:0]       addr_ext;
	logic                row_ok;
	logic                is_rd;
	logic                accept;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_right_q <= '0;
			scroll_left_q  <= '0;
			split_q        <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_SCROLL_RIGHT: scroll_right_q <= cfg.data;
				CFG_SCROLL_LEFT:  scroll_left_q  <= cfg.data;
				CFG_SPLIT:        split_q        <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// read side: scrolled column wraps at the layer width, row wraps at the height
	assign scroll   = (split_q && (req.screen_x < SX_W'(SPLIT_COLUMN))) ? scroll_left_q
		: scroll_right_q;
	assign lx_sum   = SUM_W'(req.screen_x) + SUM_W'(scroll);
	assign lx       = lx_sum[XW-1:0];
	assign sy_ext   = YE_W'(req.screen_y);
	assign ly       = sy_ext[YW-1:0];
	assign rd_idx   = {ly, lx[XW-1:1]};

	// write side: rows past the layer are dropped
	assign addr_ext = AW'(req.word_addr);
	assign row_ok   = (addr_ext >> IW) == '0;

	assign is_rd     = (req.op == OP_READ);
	assign req.ready = !q_full && !clr_busy;
	assign accept    = req.valid && req.ready;
	assign push      = accept && (is_rd || (row_ok && (req.byte_mask != '0)));

	always_comb begin
		push_cmd          = '0;
		push_cmd.is_rd    = is_rd;
		push_cmd.odd_sel  = lx[0];
		push_cmd.even_we  = !is_rd && req.byte_mask[MASK_EVEN_BIT];
		push_cmd.odd_we   = !is_rd && req.byte_mask[MASK_ODD_BIT];
		push_cmd.even_nib = req.write_data[11:8];
		push_cmd.odd_nib  = req.write_data[3:0];
		push_idx          = is_rd ? rd_idx : addr_ext[IW-1:0];
	end

endmodule

[rtl/core/snpl_fifo.sv]
`timescale 1ns / 1ps
module snpl_fifo #(
	parameter int DW = 29
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output logic [DW-1:0] head
);

	logic [DW-1:0] entry_q [2];
	logic          wptr_q;
	logic          rptr_q;
	logic [1:0]    cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/core/snpl_back.sv]
`timescale 1ns / 1ps
`include "scrolled_nibble_pixel_layer_macros.svh"
module snpl_back import snpl_pkg::*; #(
	parameter int IW = 18
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  snpl_cmd_t     head_cmd,
	input  logic [IW-1:0] head_idx,
	output logic          pop,
	output logic          clr_busy,
	snpl_rsp_if.source    rsp
);

	localparam int DEPTH = 1 << IW;

	// even pixel (write_data 11:8) and odd pixel (write_data 3:0) kept in separate arrays
	logic [NIB_W-1:0] even_mem [DEPTH];
	logic [NIB_W-1:0] odd_mem  [DEPTH];

	logic             clr_busy_q;
	logic [IW-1:0]    clr_addr_q;
	logic             vld_s1;
	logic             odd_sel_s1;
	logic [NIB_W-1:0] even_rd_s1;
	logic [NIB_W-1:0] odd_rd_s1;

	logic             rd_en;
	logic             even_we;
	logic             odd_we;
	logic [IW-1:0]    mem_addr;
	logic [NIB_W-1:0] even_wd;
	logic [NIB_W-1:0] odd_wd;

	assign clr_busy = clr_busy_q;

	// a read may leave the queue only if the result slot frees up this cycle
	assign pop = !empty && !clr_busy_q && (!head_cmd.is_rd || !vld_s1 || rsp.ready);

	assign rd_en    = pop && head_cmd.is_rd;
	assign even_we  = clr_busy_q || (pop && head_cmd.even_we);
	assign odd_we   = clr_busy_q || (pop && head_cmd.odd_we);
	assign mem_addr = clr_busy_q ? clr_addr_q : head_idx;
	assign even_wd  = clr_busy_q ? '0 : head_cmd.even_nib;
	assign odd_wd   = clr_busy_q ? '0 : head_cmd.odd_nib;

	always_ff @(posedge clk) begin
		if (even_we) begin
			even_mem[mem_addr] <= even_wd;
		end
		if (rd_en) begin
			even_rd_s1 <= even_mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (odd_we) begin
			odd_mem[mem_addr] <= odd_wd;
		end
		if (rd_en) begin
			odd_rd_s1 <= odd_mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			odd_sel_s1 <= head_cmd.odd_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			vld_s1     <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (&clr_addr_q) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (rd_en) begin
				vld_s1 <= 1'b1;
			end else if (rsp.ready) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	assign rsp.valid        = vld_s1;
	assign rsp.pixel_nibble = odd_sel_s1 ? odd_rd_s1 : even_rd_s1;
	assign rsp.opaque       = |rsp.pixel_nibble;

	`SNPL_ASSERT_NEXT(a_clear_ends, clk, arst_n, clr_busy_q && (&clr_addr_q), !clr_busy_q)
	`SNPL_ASSERT_NEXT(a_clear_once, clk, arst_n, !clr_busy_q, !clr_busy_q)
	`SNPL_ASSERT_NEXT(a_read_lands, clk, arst_n, pop && head_cmd.is_rd, vld_s1)
	`SNPL_ASSERT_NEXT(a_result_held, clk, arst_n, vld_s1 && !rsp.ready,
		vld_s1 && $stable(even_rd_s1) && $stable(odd_rd_s1) && $stable(odd_sel_s1))

endmodule

[rtl/core/scrolled_nibble_pixel_layer.sv]
`timescale 1ns / 1ps
// Scrolled four-bit pixel layer with a CPU write port and a screen read port.
// req carries one word per item: op selects a pixel-pair write (word_addr,
// write_data nibbles 11:8 and 3:0, byte_mask lanes) or a screen read
// (screen_x, screen_y). A write returns nothing; a read returns one word on
// rsp with pixel_nibble and opaque. cfg writes scroll_right (index 0),
// scroll_left (index 1) and split_window (index 2); the user writes them
// only while the layer is idle; the layer does not enforce this. Items pass
// a two-entry queue between the accepting front end and the store; a read
// then passes the store's read register, which drives rsp. One item is
// taken per cycle while req.ready is high, bounded by the single access
// port of the pixel store. After reset the store is swept to zero, one
// pixel pair a cycle, over all (LAYER_WIDTH/2)*LAYER_HEIGHT pairs (262144
// at the default size); req.ready stays low meanwhile, cfg writes are taken
// as ever. When rsp stalls, the result stays in its output register, writes
// drain up to the next read, and the queue fills before req.ready drops.
// LAYER_WIDTH and LAYER_HEIGHT must be powers of two; this is not checked.
module scrolled_nibble_pixel_layer import snpl_pkg::*; #(
	parameter int LAYER_WIDTH  = 2048,
	parameter int LAYER_HEIGHT = 256,
	parameter int SPLIT_COLUMN = 160
) (
	input  logic       clk,
	input  logic       arst_n,
	snpl_req_if.sink   req,
	snpl_rsp_if.source rsp,
	snpl_cfg_if.sink   cfg
);

	localparam int IW = $clog2(LAYER_WIDTH) - 1 + $clog2(LAYER_HEIGHT);
	localparam int CW = $bits(snpl_cmd_t);
	localparam int DW = CW + IW;

	logic          clr_busy;
	logic          q_full;
	logic          q_empty;
	logic          push;
	logic          pop;
	snpl_cmd_t     push_cmd;
	logic [IW-1:0] push_idx;
	logic [DW-1:0] head;
	snpl_cmd_t     head_cmd;
	logic [IW-1:0] head_idx;

	snpl_front #(
		.LAYER_WIDTH  (LAYER_WIDTH),
		.LAYER_HEIGHT (LAYER_HEIGHT),
		.SPLIT_COLUMN (SPLIT_COLUMN),
		.IW           (IW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg      (cfg),
		.clr_busy (clr_busy),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd),
		.push_idx (push_idx)
	);

	snpl_fifo #(
		.DW (DW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_cmd, push_idx}),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (head)
	);

	assign head_cmd = snpl_cmd_t'(head[DW-1:IW]);
	assign head_idx = head[IW-1:0];

	snpl_back #(
		.IW (IW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.head_cmd (head_cmd),
		.head_idx (head_idx),
		.pop      (pop),
		.clr_busy (clr_busy),
		.rsp      (rsp)
	);

endmodule
